### sv/wbps_pkg.sv
// shared types and constants of the wildcard byte pattern scanner
package wbps_pkg;

  localparam int unsigned SigBytes   = 16;
  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned LenWidth   = 5;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgWidth   = 64;

  localparam logic [CfgIdxBits-1:0] REG_SIG_LOW  = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_SIG_HIGH = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_CARE     = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_LENGTH   = 3'd3;
  localparam logic [CfgIdxBits-1:0] REG_BASE     = 3'd4;

  // per-transfer control shared by every cell of the window
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // what one cell compares its byte against
  typedef struct packed {
    logic [7:0] exp_byte;
    logic       care;
    logic       active;
  } cell_cfg_t;

endpackage

### sv/wbps_cell.sv
// one window cell: holds a byte, passes it on and compares the incoming byte
module wbps_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wbps_pkg::cell_ctrl_t ctrl,
  input  wbps_pkg::cell_cfg_t  cfg,
  input  logic [7:0]          byte_in,
  output logic [7:0]          byte_out,
  output logic                hit
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (ctrl.shift) begin
      byte_nxt = ctrl.clear ? 8'd0 : byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'd0;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // compare against the window as it stands after this transfer
  assign hit      = !cfg.active || !cfg.care || (byte_in == cfg.exp_byte);
  assign byte_out = byte_r;

endmodule

### sv/wildcard_byte_pattern_scanner_top.sv
// top level of the wildcard byte pattern scanner
// Takes one region byte per cycle, one transfer per clock, unless input stalls: each
// byte shifts into a row of MAX_SIGNATURE cells that all compare in the same
// cycle, and the result is registered in the output buffer.
// A two-entry output buffer lets input continue while a result waits; input
// stalls only when both entries are full. There is no clearing pass after reset.
module wildcard_byte_pattern_scanner_top #(
  parameter int unsigned MAX_SIGNATURE = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,   // data_byte
  input  logic                                  in_tlast,   // last_byte
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [wbps_pkg::AddrWidth-1:0]        out_tdata,  // match_address
  output logic                                  out_tuser,  // found
  input  logic                                  cfg_we,
  input  logic [wbps_pkg::CfgIdxBits-1:0]       cfg_index,
  input  logic [wbps_pkg::CfgWidth-1:0]         cfg_wdata
);

  localparam int unsigned AW = wbps_pkg::AddrWidth;
  localparam int unsigned LW = wbps_pkg::LenWidth;
  localparam logic [LW-1:0] MaxLen = LW'(MAX_SIGNATURE);

  // configuration registers
  logic [63:0]   sig_low_r;
  logic [63:0]   sig_high_r;
  logic [15:0]   care_r;
  logic [LW-1:0] length_r;
  logic [AW-1:0] base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_low_r  <= 64'd0;
      sig_high_r <= 64'd0;
      care_r     <= 16'hFFFF;
      length_r   <= LW'(1);
      base_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        wbps_pkg::REG_SIG_LOW:  sig_low_r  <= cfg_wdata;
        wbps_pkg::REG_SIG_HIGH: sig_high_r <= cfg_wdata;
        wbps_pkg::REG_CARE:     care_r     <= cfg_wdata[15:0];
        wbps_pkg::REG_LENGTH:   length_r   <= cfg_wdata[LW-1:0];
        wbps_pkg::REG_BASE:     base_r     <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  // clamped length
  logic [LW-1:0] len_c;
  always_comb begin
    len_c = length_r;
    if (len_c == '0)   len_c = LW'(1);
    if (len_c > MaxLen) len_c = MaxLen;
  end

  logic [127:0] sig_all;
  assign sig_all = {sig_high_r, sig_low_r};

  logic accept;
  assign accept = in_tvalid && in_tready;

  wbps_pkg::cell_ctrl_t ctrl;
  assign ctrl.shift = accept;
  assign ctrl.clear = in_tlast;

  // row of cells
  logic [7:0]               link [MAX_SIGNATURE+1];
  logic [MAX_SIGNATURE-1:0] hits;

  assign link[0] = in_tdata;

  for (genvar j = 0; j < MAX_SIGNATURE; j++) begin : g_cell
    wbps_pkg::cell_cfg_t ccfg;
    logic [LW-1:0]       k_full;
    assign k_full       = len_c - LW'(1) - LW'(j);
    assign ccfg.active  = (LW'(j) < len_c);
    assign ccfg.care    = care_r[k_full[3:0]];
    assign ccfg.exp_byte = sig_all[{k_full[3:0], 3'b000} +: 8];

    wbps_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .cfg      (ccfg),
      .byte_in  (link[j]),
      .byte_out (link[j+1]),
      .hit      (hits[j])
    );
  end

  // region tracking
  logic [AW-1:0] seen_r, seen_nxt;
  logic          reported_r, reported_nxt;
  logic [AW-1:0] seen_inc;
  logic          match;
  logic          res_v;
  logic [AW-1:0] res_addr;

  assign seen_inc = (seen_r == '1) ? seen_r : seen_r + AW'(1);
  assign match    = !reported_r && (seen_inc >= AW'(len_c)) && (&hits);
  assign res_v    = accept && (match || (in_tlast && !reported_r));
  assign res_addr = match ? (base_r + (seen_inc - AW'(len_c))) : '0;

  always_comb begin
    seen_nxt     = seen_r;
    reported_nxt = reported_r;
    if (accept) begin
      if (in_tlast) begin
        seen_nxt     = '0;
        reported_nxt = 1'b0;
      end else begin
        seen_nxt     = seen_inc;
        reported_nxt = reported_r || match;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      reported_r <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      reported_r <= reported_nxt;
    end
  end

  // two-entry output buffer
  logic          out_valid_r, out_valid_nxt;
  logic          skid_valid_r, skid_valid_nxt;
  logic [AW-1:0] out_addr_r, out_addr_nxt, skid_addr_r, skid_addr_nxt;
  logic          out_found_r, out_found_nxt, skid_found_r, skid_found_nxt;

  assign in_tready = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_addr_nxt   = out_addr_r;
    out_found_nxt  = out_found_r;
    skid_valid_nxt = skid_valid_r;
    skid_addr_nxt  = skid_addr_r;
    skid_found_nxt = skid_found_r;
    if (out_valid_r && !out_tready) begin
      if (res_v) begin
        skid_valid_nxt = 1'b1;
        skid_addr_nxt  = res_addr;
        skid_found_nxt = match;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt  = 1'b1;
      out_addr_nxt   = skid_addr_r;
      out_found_nxt  = skid_found_r;
      skid_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = res_v;
      out_addr_nxt  = res_addr;
      out_found_nxt = match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_addr_r   <= out_addr_nxt;
    out_found_r  <= out_found_nxt;
    skid_addr_r  <= skid_addr_nxt;
    skid_found_r <= skid_found_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_found_r;

endmodule

### sv/wbps_checker.sv
// port-level checker for the wildcard byte pattern scanner, with its bind
module wbps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wbps_pkg::AddrWidth-1:0]  out_tdata,
  input logic                            out_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a not-found result carries a zero address
  a_nf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("not-found result with non-zero address");

  // no result straight after reset
  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // input only stalls while a result is waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

endmodule

bind wildcard_byte_pattern_scanner_top wbps_checker u_wbps_checker (.*);

### test/tb.sv
// testbench of the byte pattern scanner: byte regions in, each result checked against a predictor
module tb;

  localparam int CycleLimit  = 1000000;
  localparam int RandomBytes = 1400;
  localparam int DrainCycles = 8;

  localparam int unsigned SigBytes   = wbps_pkg::SigBytes;
  localparam int unsigned AddrWidth  = wbps_pkg::AddrWidth;
  localparam int unsigned LenWidth   = wbps_pkg::LenWidth;
  localparam int unsigned CfgIdxBits = wbps_pkg::CfgIdxBits;
  localparam int unsigned CfgWidth   = wbps_pkg::CfgWidth;

  typedef struct packed {
    logic                 found;
    logic [AddrWidth-1:0] addr;
  } scan_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata   = '0;
  logic                  in_tlast   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [AddrWidth-1:0]  out_tdata;
  logic                  out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index  = '0;
  logic [CfgWidth-1:0]   cfg_wdata  = '0;

  // predictor copy of the registers and the scan state
  logic [63:0]          sig_lo;
  logic [63:0]          sig_hi;
  logic [15:0]          care;
  logic [LenWidth-1:0]  len_reg;
  logic [AddrWidth-1:0] base;
  logic [7:0]           recent_bytes [SigBytes];
  logic [31:0]          seen;
  logic                 reported;

  scan_result_t expected_hits [$];
  scan_result_t oldest_hit;
  logic [7:0]   region_bytes [$];
  int           errors     = 0;
  int           bytes_sent = 0;
  int           cycles     = 0;
  int           ready_hold = 0;
  bit           idle_en    = 1'b1;
  bit           stall_en   = 1'b1;

  wildcard_byte_pattern_scanner_top u_top (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int used_len();
    if (len_reg == 0) return 1;
    if (len_reg > SigBytes) return SigBytes;
    return len_reg;
  endfunction

  function automatic logic [7:0] sig_byte(int k);
    logic [127:0] sig;
    sig = {sig_hi, sig_lo};
    return sig[8*k +: 8];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic clear_region();
    for (int i = 0; i < SigBytes; i++) recent_bytes[i] = '0;
    seen     = '0;
    reported = 1'b0;
  endtask

  task automatic scan_step(input logic [7:0] b, input logic last);
    int           n;
    bit           hit;
    scan_result_t r;
    n = used_len();
    for (int i = SigBytes - 1; i > 0; i--) recent_bytes[i] = recent_bytes[i-1];
    recent_bytes[0] = b;
    if (seen != '1) seen = seen + 1;
    if (!reported && seen >= n) begin
      hit = 1'b1;
      for (int k = 0; k < n; k++)
        if (care[k] && recent_bytes[n-1-k] != sig_byte(k)) hit = 1'b0;
      if (hit) begin
        r.found = 1'b1;
        r.addr  = base + seen - n;
        expected_hits.push_back(r);
        reported = 1'b1;
      end
    end
    if (last) begin
      if (!reported) begin
        r.found = 1'b0;
        r.addr  = '0;
        expected_hits.push_back(r);
      end
      clear_region();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = (idle_en && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_step(b, last);
    bytes_sent++;
  endtask

  task automatic send_region();
    for (int i = 0; i < region_bytes.size(); i++)
      send_byte(region_bytes[i], i == region_bytes.size() - 1);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgWidth-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      wbps_pkg::REG_SIG_LOW:  sig_lo = value;
      wbps_pkg::REG_SIG_HIGH: sig_hi = value;
      wbps_pkg::REG_CARE:     care = value[15:0];
      wbps_pkg::REG_LENGTH:   len_reg = value[LenWidth-1:0];
      wbps_pkg::REG_BASE:     base = value[AddrWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_signature(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [15:0] c, input logic [4:0] l,
                                input logic [31:0] b);
    write_reg(wbps_pkg::REG_SIG_LOW, lo);
    write_reg(wbps_pkg::REG_SIG_HIGH, hi);
    write_reg(wbps_pkg::REG_CARE, CfgWidth'(c));
    write_reg(wbps_pkg::REG_LENGTH, CfgWidth'(l));
    write_reg(wbps_pkg::REG_BASE, CfgWidth'(b));
  endtask

  // reset values: one-byte signature of zero, every byte cared for
  task automatic test_defaults();
    region_bytes = '{8'hFF, 8'h00};
    send_region();
    wait_idle();
  endtask

  // zero length acts as one, all wildcards match the first byte, nothing on the last
  task automatic test_zero_length_wildcard();
    load_signature(64'h0, 64'h0, 16'h0000, 5'd0, 32'hFFFF_FFFF);
    region_bytes = '{8'hA5, 8'h5A};
    send_region();
    wait_idle();
  endtask

  // region shorter than the signature ends not found
  task automatic test_short_region();
    load_signature({$urandom, $urandom}, {$urandom, $urandom}, 16'h0000, 5'd3, 32'h0000_1000);
    region_bytes = '{8'h12, 8'h34};
    send_region();
    wait_idle();
  endtask

  // signature changed inside a region, match on the last byte, address wraps
  task automatic test_config_mid_region();
    load_signature(64'h3C, 64'h0, 16'h0001, 5'd1, 32'hFFFF_FFFE);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7E, 1'b0);
    wait_idle();
    write_reg(wbps_pkg::REG_SIG_LOW, 64'h81);
    send_byte(8'h81, 1'b1);
    wait_idle();
  endtask

  // oversized length clamps to the full sixteen bytes
  task automatic test_max_length();
    load_signature(64'h8001_7EFF_00C3_3C5A, 64'hF0E1_D2C3_B4A5_9687, 16'hFFFF, 5'd31,
                   32'h8000_0000);
    region_bytes.delete();
    for (int k = 0; k < SigBytes; k++) region_bytes.push_back(sig_byte(k));
    send_region();
    wait_idle();
  endtask

  task automatic random_config();
    logic [15:0] c;
    logic [4:0]  l;
    logic [31:0] b;
    int          r;
    case ($urandom_range(0, 5))
      0:       c = 16'hFFFF;
      1:       c = 16'h0000;
      default: c = 16'($urandom);
    endcase
    r = $urandom_range(0, 19);
    if (r == 0) l = 5'd0;
    else if (r == 1) l = 5'd16;
    else if (r == 2) l = 5'($urandom_range(17, 31));
    else if (r < 6) l = 5'($urandom_range(9, 15));
    else l = 5'($urandom_range(1, 8));
    case ($urandom_range(0, 3))
      0:       b = 32'hFFFF_FFFF - $urandom_range(0, 20);
      1:       b = $urandom_range(0, 20);
      default: b = $urandom;
    endcase
    load_signature({$urandom, $urandom}, {$urandom, $urandom}, c, l, b);
  endtask

  // mostly regions with the signature planted, some with a corrupted copy or none
  task automatic test_random_regions();
    int start;
    int regions;
    int n;
    int rlen;
    int pos;
    start   = bytes_sent;
    regions = 0;
    while (bytes_sent - start < RandomBytes) begin
      if (regions % 6 == 0) begin
        wait_idle();
        random_config();
        idle_en  = $urandom_range(0, 3) != 0;
        stall_en = $urandom_range(0, 3) != 0;
      end
      n    = used_len();
      rlen = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, n + 10);
      region_bytes.delete();
      for (int i = 0; i < rlen; i++)
        region_bytes.push_back($urandom_range(0, 1) ? sig_byte($urandom_range(0, n - 1))
                                                    : 8'($urandom));
      if (rlen >= n && $urandom_range(0, 9) < 7) begin
        pos = $urandom_range(0, rlen - n);
        for (int k = 0; k < n; k++)
          if (care[k]) region_bytes[pos+k] = sig_byte(k);
        if ($urandom_range(0, 4) == 0)
          region_bytes[pos + $urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
      send_region();
      regions++;
    end
  endtask

  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      ready_hold = pick_gap() - 1;
    end else begin
      out_tready <= 1'b1;
      ready_hold = $urandom_range(0, 6);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, actual found=%0b address=%h",
                 $time, out_tuser, out_tdata);
      end else begin
        oldest_hit = expected_hits.pop_front();
        if (out_tuser !== oldest_hit.found) begin
          errors++;
          $display("%0t: found mismatch, expected %0b actual %0b",
                   $time, oldest_hit.found, out_tuser);
        end
        if (out_tdata !== oldest_hit.addr) begin
          errors++;
          $display("%0t: match address mismatch, expected %h actual %h",
                   $time, oldest_hit.addr, out_tdata);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    sig_lo  = '0;
    sig_hi  = '0;
    care    = 16'hFFFF;
    len_reg = 5'd1;
    base    = '0;
    clear_region();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_defaults();
    test_zero_length_wildcard();
    test_short_region();
    test_config_mid_region();
    test_max_length();
    test_random_regions();
    wait_idle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
